// File: rtl/assert_macros.svh
// Assertion helpers: property form in simulation, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/mtac_pkg.sv
package mtac_pkg;

  localparam int THERM_CHANNELS = 32;
  localparam logic [3:0] PASS_COUNT_RESET = 4'd10;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_POINT1 = 2'd1,
    CMD_POINT2 = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         channel;
    logic signed [31:0] sample;
    logic signed [31:0] reference_temp;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         channel_out;
    logic signed [31:0] temperature;
    logic               was_calibrated;
    logic               divide_fault;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_DIVDONE,
    ST_CLEAR,
    ST_RPT_READ,
    ST_RPT_WAIT,
    ST_RPT_EXEC,
    ST_RPT_DIV,
    ST_RPT_OUT
  } state_t;

  // Saturate to 32 bits: the Q16.16 division result and the point-one offset
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (x < -64'sh80000000) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// File: rtl/multichannel_temp_average_calibrate.sv
// Channel    | Direction | Handshake        | Payload
// in         | input     | in_valid/ready   | mtac_pkg::in_item_t
// out        | output    | out_valid/ready  | mtac_pkg::out_item_t
// cfg        | input     | cfg_valid/ready  | pass_count [3:0]
// A sample is handled as memory read, update and write back; point two
// waits on the bit-serial divider. Clear sweeps the calibration memory.
// A report reads each channel in turn, dividing each calibrated result,
// and waits on output stall. Reset clears the averages memory by valid
// bits; the calibration store is cleared by a sweep after reset before
// items are taken.
module multichannel_temp_average_calibrate #(
  parameter int THERMISTOR_CHANNELS = mtac_pkg::THERM_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtac_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtac_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);

  localparam int NCH = THERMISTOR_CHANNELS + 1;
  localparam int AW  = $clog2(NCH);
  localparam int CW  = (THERMISTOR_CHANNELS > 1) ? $clog2(THERMISTOR_CHANNELS) : 1;

  mtac_pkg::state_t state, state_next;

  // Average memory with per-entry valid bits, calibration memory {offset, gain}
  logic signed [31:0] avg_mem [NCH];
  logic [63:0]        cal_mem [THERMISTOR_CHANNELS];
  logic [NCH-1:0]     avg_valid;
  logic signed [31:0] avg_rd;
  logic [63:0]        cal_rd;
  logic               avg_rd_v;

  logic [3:0]         pass_count;
  logic [3:0]         pass_counter;
  logic               calibrated;
  mtac_pkg::in_item_t item;
  logic [AW-1:0]      idx;
  logic [AW:0]        sweep;
  logic               sweeping;

  logic               div_start, div_done, div_fault;
  logic signed [32:0] div_num;
  logic signed [31:0] div_den, div_quot;

  logic signed [31:0] avg_cur;
  logic signed [32:0] sum;
  logic signed [31:0] avg_new;
  logic               is_int;
  logic [3:0]         pc_inc;
  logic [3:0]         pc_eff;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == mtac_pkg::ST_IDLE) && !sweeping;

  // Hold the pass count
  always_ff @(posedge clk) begin
    if (rst) pass_count <= mtac_pkg::PASS_COUNT_RESET;
    else if (cfg_valid) pass_count <= cfg_data;
  end

  assign avg_cur = avg_rd_v ? avg_rd : 32'sd0;
  assign sum     = 33'(avg_cur) + 33'(item.sample);
  assign avg_new = (avg_cur == 32'sd0) ? item.sample : 32'(sum / 33'sd2);
  assign is_int  = item.channel == 6'(THERMISTOR_CHANNELS);
  assign pc_inc  = pass_counter + 4'd1;
  assign pc_eff  = (pass_count == 4'd0) ? 4'd1 : pass_count;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mtac_pkg::ST_IDLE:
        if (in_valid && in_ready) begin
          if (in_data.command == mtac_pkg::CMD_CLEAR) state_next = mtac_pkg::ST_CLEAR;
          else if (in_data.command == mtac_pkg::CMD_SAMPLE
                   ? in_data.channel <= 6'(THERMISTOR_CHANNELS)
                   : in_data.channel < 6'(THERMISTOR_CHANNELS))
            state_next = mtac_pkg::ST_READ;
        end
      mtac_pkg::ST_READ: state_next = mtac_pkg::ST_EXEC;
      mtac_pkg::ST_EXEC:
        if (item.command == mtac_pkg::CMD_POINT2) state_next = mtac_pkg::ST_DIV;
        else if (item.command == mtac_pkg::CMD_SAMPLE && is_int && pc_inc >= pc_eff)
          state_next = mtac_pkg::ST_RPT_READ;
        else state_next = mtac_pkg::ST_IDLE;
      mtac_pkg::ST_DIV: if (div_done) state_next = mtac_pkg::ST_IDLE;
      mtac_pkg::ST_DIVDONE: state_next = mtac_pkg::ST_IDLE;
      mtac_pkg::ST_CLEAR: state_next = mtac_pkg::ST_IDLE;
      mtac_pkg::ST_RPT_READ: state_next = mtac_pkg::ST_RPT_WAIT;
      mtac_pkg::ST_RPT_WAIT: state_next = mtac_pkg::ST_RPT_EXEC;
      mtac_pkg::ST_RPT_EXEC:
        state_next = (calibrated && idx != AW'(THERMISTOR_CHANNELS))
                     ? mtac_pkg::ST_RPT_DIV : mtac_pkg::ST_RPT_OUT;
      mtac_pkg::ST_RPT_DIV: if (div_done) state_next = mtac_pkg::ST_RPT_OUT;
      mtac_pkg::ST_RPT_OUT:
        if (out_ready)
          state_next = (idx == AW'(THERMISTOR_CHANNELS))
                       ? mtac_pkg::ST_IDLE : mtac_pkg::ST_RPT_READ;
      default: state_next = mtac_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    out_valid = (state == mtac_pkg::ST_RPT_OUT);
    div_start = 1'b0;
    div_num   = 33'(sum);
    div_den   = item.reference_temp;
    if (state == mtac_pkg::ST_EXEC && item.command == mtac_pkg::CMD_POINT2) begin
      div_start = 1'b1;
      div_num   = 33'(item.sample) - 33'($signed(cal_rd[63:32]));
      div_den   = item.reference_temp;
    end else if (state == mtac_pkg::ST_RPT_EXEC && calibrated
                 && idx != AW'(THERMISTOR_CHANNELS)) begin
      div_start = 1'b1;
      div_num   = 33'(avg_cur) - 33'($signed(cal_rd[63:32]));
      div_den   = $signed(cal_rd[31:0]);
    end
  end

  mtac_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot), .fault(div_fault)
  );

  // Read the memories
  always_ff @(posedge clk) begin
    avg_rd   <= avg_mem[idx];
    avg_rd_v <= avg_valid[idx];
    cal_rd   <= cal_mem[CW'(idx)];
  end

  // Sequencer, memory writes and report
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mtac_pkg::ST_IDLE;
      avg_valid    <= '0;
      pass_counter <= 4'd0;
      calibrated   <= 1'b0;
      sweeping     <= 1'b1;
      sweep        <= '0;
      idx          <= '0;
    end else begin
      state <= state_next;
      if (sweeping || state == mtac_pkg::ST_CLEAR) begin
        cal_mem[CW'(sweep)] <= '0;
        if (sweep == (AW+1)'(THERMISTOR_CHANNELS - 1)) begin
          sweeping <= 1'b0;
          sweep    <= '0;
        end else begin
          sweep <= sweep + 1'b1;
        end
      end
      unique case (state)
        mtac_pkg::ST_IDLE:
          if (in_valid && in_ready) begin
            item <= in_data;
            idx  <= AW'(in_data.channel);
            if (in_data.command == mtac_pkg::CMD_CLEAR) begin
              calibrated <= 1'b0;
              sweeping   <= 1'b1;
              sweep      <= '0;
            end
          end
        mtac_pkg::ST_EXEC:
          if (item.command == mtac_pkg::CMD_SAMPLE) begin
            avg_mem[idx]   <= avg_new;
            avg_valid[idx] <= 1'b1;
            if (is_int) begin
              if (pc_inc >= pc_eff) begin
                pass_counter <= 4'd0;
                idx          <= '0;
              end else begin
                pass_counter <= pc_inc;
              end
            end
          end else if (item.command == mtac_pkg::CMD_POINT1) begin
            cal_mem[CW'(idx)] <= {mtac_pkg::sat32(64'(item.reference_temp)
                                  - 64'(item.sample)), cal_rd[31:0]};
          end
        mtac_pkg::ST_DIV:
          if (div_done) begin
            cal_mem[CW'(idx)] <= {cal_rd[63:32], div_quot};
            if (idx == AW'(THERMISTOR_CHANNELS - 1)) calibrated <= 1'b1;
          end
        mtac_pkg::ST_RPT_EXEC: begin
          out_data.channel_out    <= 6'(idx);
          out_data.temperature    <= avg_cur;
          out_data.was_calibrated <= calibrated && idx != AW'(THERMISTOR_CHANNELS);
          out_data.divide_fault   <= 1'b0;
          out_data.last           <= idx == AW'(THERMISTOR_CHANNELS);
          avg_valid[idx]          <= 1'b0;
        end
        mtac_pkg::ST_RPT_DIV:
          if (div_done) begin
            out_data.temperature  <= div_quot;
            out_data.divide_fault <= div_fault;
          end
        mtac_pkg::ST_RPT_OUT:
          if (out_ready && idx != AW'(THERMISTOR_CHANNELS)) idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_in_only_idle, clk, rst, in_valid && in_ready, state == mtac_pkg::ST_IDLE)
  `ASSERT_IMPLIES(a_last_internal, clk, rst, out_valid && out_data.last, !out_data.was_calibrated)
  `ASSERT_NEXT(a_last_ends, clk, rst, out_valid && out_ready && out_data.last,
               state == mtac_pkg::ST_IDLE)
  `ASSERT_IMPLIES(a_no_in_sweep, clk, rst, sweeping, !in_ready)

endmodule

// File: rtl/mtac_divider.sv
// Signed divider: (num << 16) / den, one quotient bit a cycle, truncating,
// saturated to 32 bits. Zero divisor saturates by numerator sign and flags.
module mtac_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot,
  output logic               fault
);

  localparam int NW = 49;

  logic [NW-1:0] rem_q;   // dividend shifting out, quotient shifting in
  logic [32:0]   part;    // partial remainder
  logic [31:0]   dmag;
  logic          neg;
  logic          busy;
  logic [5:0]    cnt;
  logic [33:0]   trial;
  logic [NW-1:0] numag;
  logic signed [NW:0] sq;

  assign trial = {part, rem_q[NW-1]} - {2'b00, dmag};
  assign numag = num[32] ? NW'(-{{16{num[32]}}, num}) << 16 :
                 NW'({{16{num[32]}}, num}) << 16;
  assign sq = neg ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});

  // Run the restoring loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 32'sd0) begin
          quot  <= num[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
          fault <= 1'b1;
          done  <= 1'b1;
        end else begin
          busy  <= 1'b1;
          cnt   <= 6'(NW);
          rem_q <= numag;
          part  <= '0;
          dmag  <= den[31] ? 32'(-den) : den;
          neg   <= num[32] ^ den[31];
          fault <= 1'b0;
        end
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= mtac_pkg::sat32(64'(sq));
        end else begin
          cnt <= cnt - 6'd1;
          if (!trial[33]) part <= trial[32:0];
          else part <= {part[31:0], rem_q[NW-1]};
          rem_q <= {rem_q[NW-2:0], ~trial[33]};
        end
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_zero_div_done, clk, rst, start && den == 32'sd0, done && fault)
  `ASSERT_IMPLIES(a_no_start_busy, clk, rst, busy, !start)
  `ASSERT_NEXT(a_busy_no_done, clk, rst, busy && cnt != 6'd0, !done)

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int NCH = mtac_pkg::THERM_CHANNELS;
  localparam int WATCHDOG_LIMIT = 20000;

  // Average and calibration state of the block, kept alongside it
  class temp_scoreboard;
    logic signed [31:0] avg_mem [NCH+1];
    logic signed [31:0] offset_mem [NCH];
    logic signed [31:0] gain_mem [NCH];
    logic [3:0] passes_seen;
    logic [3:0] passes_needed;
    bit cal_done;
    mtac_pkg::out_item_t pending_q[$];
    int errors;

    function void clear_all();
      foreach (avg_mem[i]) avg_mem[i] = '0;
      foreach (offset_mem[i]) begin
        offset_mem[i] = '0;
        gain_mem[i] = '0;
      end
      passes_seen = '0;
      passes_needed = mtac_pkg::PASS_COUNT_RESET;
      cal_done = 0;
      pending_q.delete();
      errors = 0;
    endfunction

    function logic signed [31:0] clip32(input logic signed [63:0] x);
      if (x > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (x < -64'sh80000000) return 32'sh80000000;
      return x[31:0];
    endfunction

    // Q16.16 quotient, saturated; fault when the divisor is zero
    function logic signed [31:0] q_divide(input logic signed [63:0] num,
                                          input logic signed [31:0] den,
                                          output bit fault);
      logic signed [63:0] scaled;
      scaled = num * 64'sd65536;
      fault = (den == 0);
      if (fault) return (num >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      return clip32(scaled / 64'(den));
    endfunction

    function void note_input(input mtac_pkg::in_item_t it);
      logic signed [63:0] s, r, a;
      logic signed [31:0] t;
      mtac_pkg::out_item_t res;
      bit flt;
      int ch;
      s = 64'(it.sample);
      r = 64'(it.reference_temp);
      ch = it.channel;
      case (mtac_pkg::cmd_t'(it.command))
        mtac_pkg::CMD_CLEAR: begin
          foreach (offset_mem[i]) begin
            offset_mem[i] = '0;
            gain_mem[i] = '0;
          end
          cal_done = 0;
        end
        mtac_pkg::CMD_POINT1: if (ch < NCH) offset_mem[ch] = clip32(r - s);
        mtac_pkg::CMD_POINT2: if (ch < NCH) begin
          gain_mem[ch] = q_divide(s - 64'(offset_mem[ch]), it.reference_temp, flt);
          if (ch == NCH - 1) cal_done = 1;
        end
        default: if (ch <= NCH) begin
          if (avg_mem[ch] == 0) avg_mem[ch] = it.sample;
          else begin
            a = (64'(avg_mem[ch]) + s) / 2;
            avg_mem[ch] = a[31:0];
          end
          if (ch == NCH) begin
            passes_seen = passes_seen + 1;
            if (passes_seen >= passes_needed) begin
              // Queue the report: thermistors first, internal channel last
              for (int i = 0; i < NCH; i++) begin
                t = avg_mem[i];
                flt = 0;
                if (cal_done) t = q_divide(64'(t) - 64'(offset_mem[i]), gain_mem[i], flt);
                res.channel_out = 6'(i);
                res.temperature = t;
                res.was_calibrated = cal_done;
                res.divide_fault = flt;
                res.last = 0;
                pending_q.push_back(res);
              end
              res.channel_out = 6'(NCH);
              res.temperature = avg_mem[NCH];
              res.was_calibrated = 0;
              res.divide_fault = 0;
              res.last = 1;
              pending_q.push_back(res);
              foreach (avg_mem[i]) avg_mem[i] = '0;
              passes_seen = '0;
            end
          end
        end
      endcase
    endfunction

    task check_result(input mtac_pkg::out_item_t got);
      mtac_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 0, got.temperature);
        return;
      end
      want = pending_q.pop_front();
      if (got.channel_out !== want.channel_out)
        report_mismatch("channel_out", want.channel_out, got.channel_out);
      if (got.temperature !== want.temperature)
        report_mismatch("temperature", want.temperature, got.temperature);
      if (got.was_calibrated !== want.was_calibrated)
        report_mismatch("was_calibrated", want.was_calibrated, got.was_calibrated);
      if (got.divide_fault !== want.divide_fault)
        report_mismatch("divide_fault", want.divide_fault, got.divide_fault);
      if (got.last !== want.last)
        report_mismatch("last", want.last, got.last);
    endtask

    task report_mismatch(input string what, input longint want, input longint got);
      errors++;
      $display("mismatch %s: expected %0h got %0h", what, want, got);
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  mtac_pkg::in_item_t in_data;
  mtac_pkg::out_item_t out_data;
  logic [3:0] cfg_data;

  temp_scoreboard board;
  int in_idle_pct, out_idle_pct;
  int quiet_cycles;

  multichannel_temp_average_calibrate DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receive side: random stall, check each accepted result
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) board.check_result(out_data);
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Drop valid only while idling, so items can follow back to back
  task automatic send_item(input mtac_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    board.note_input(it);
  endtask

  task automatic send_cmd(input mtac_pkg::cmd_t c, input int ch, input logic [31:0] s,
                          input logic [31:0] r);
    mtac_pkg::in_item_t it;
    it.command = c;
    it.channel = 6'(ch);
    it.sample = s;
    it.reference_temp = r;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Idle write of the pass count
  task automatic set_pass_count(input logic [3:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.passes_needed = v;
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_temp();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(65536 * 100)) - 32'd3276800;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Sweep of two-point calibration over all thermistors, ending on the last
  task automatic calibrate_all();
    for (int c = 0; c < NCH; c++) begin
      send_cmd(mtac_pkg::CMD_POINT1, c, rand_temp(), rand_temp());
      if ($urandom_range(9) == 0) send_cmd(mtac_pkg::CMD_POINT2, c, rand_temp(), '0);
      else send_cmd(mtac_pkg::CMD_POINT2, c, rand_temp(),
                    32'($urandom_range(65536 * 4, 1)));
    end
  endtask

  // One scan pass: random thermistor samples then the internal channel
  task automatic scan_pass();
    int n;
    n = $urandom_range(6, 1);
    for (int k = 0; k < n; k++)
      send_cmd(mtac_pkg::CMD_SAMPLE, $urandom_range(NCH - 1), rand_temp(), $urandom);
    send_cmd(mtac_pkg::CMD_SAMPLE, NCH, rand_temp(), $urandom);
  endtask

  initial begin
    board = new();
    board.clear_all();
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    in_idle_pct = 26;
    out_idle_pct = 53;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: extremes, each command, ignored channels, zero divisor
    send_cmd(mtac_pkg::CMD_SAMPLE, 0, 32'h7FFFFFFF, 0);
    send_cmd(mtac_pkg::CMD_SAMPLE, 0, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_cmd(mtac_pkg::CMD_SAMPLE, 31, 32'h80000000, 0);
    send_cmd(mtac_pkg::CMD_SAMPLE, 31, 32'h80000000, 0);
    send_cmd(mtac_pkg::CMD_SAMPLE, 5, 0, 0);
    send_cmd(mtac_pkg::CMD_SAMPLE, 63, 32'h12345678, 0);
    send_cmd(mtac_pkg::CMD_SAMPLE, 33, 32'h00010000, 0);
    send_cmd(mtac_pkg::CMD_POINT1, 32, 1, 2);
    send_cmd(mtac_pkg::CMD_POINT2, 63, 1, 2);
    send_cmd(mtac_pkg::CMD_POINT1, 3, 32'h80000000, 32'h7FFFFFFF);
    send_cmd(mtac_pkg::CMD_POINT2, 3, 32'h7FFFFFFF, 0);
    send_cmd(mtac_pkg::CMD_POINT1, 4, 32'h7FFFFFFF, 32'h80000000);
    send_cmd(mtac_pkg::CMD_POINT2, 4, 32'h80000000, 1);
    send_cmd(mtac_pkg::CMD_CLEAR, 63, 32'hFFFFFFFF, 32'hFFFFFFFF);
    set_pass_count(4'd1);
    send_cmd(mtac_pkg::CMD_SAMPLE, 32, 32'hFFFFFFFF, 0);
    set_pass_count(4'd0);
    send_cmd(mtac_pkg::CMD_SAMPLE, 32, 32'h00018000, 0);
    calibrate_all();
    send_cmd(mtac_pkg::CMD_SAMPLE, 7, 32'h00190000, 0);
    send_cmd(mtac_pkg::CMD_SAMPLE, 32, 32'h00100000, 0);
    set_pass_count(4'd15);

    // Random phases with different idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 53 : 0;
      out_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 26 : 0;
      for (int b = 0; b < 4; b++) begin
        if (b == 1) set_pass_count(4'($urandom_range(15)));
        if (b == 2) drain();
        if (phase == 1 && b == 3) calibrate_all();
        case ($urandom_range(4))
          0: send_cmd(mtac_pkg::CMD_CLEAR, $urandom_range(63), $urandom, $urandom);
          1: send_cmd(mtac_pkg::cmd_t'($urandom_range(3)), $urandom_range(63),
                      $urandom, $urandom);
          default: ;
        endcase
        for (int p = 0; p < 3; p++) scan_pass();
      end
      set_pass_count(phase == 2 ? 4'd15 : 4'd2);
    end

    drain();
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
